// ===== rtl/dssp_pkg.sv =====
`default_nettype none
package dssp_pkg;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_U      = 3'd3,
		PH_M      = 3'd4,
		PH_END    = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_MINUS   = 3'd1,
		ST_NODIG   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_SUFFIX  = 3'd4,
		ST_GARBAGE = 3'd5,
		ST_OVFL    = 3'd6
	} status_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_H     = 8'h68;

	localparam logic [31:0] FACT_US  = 32'd1;
	localparam logic [31:0] FACT_MS  = 32'd1000;
	localparam logic [31:0] FACT_SEC = 32'd1000000;
	localparam logic [31:0] FACT_MIN = 32'd60000000;
	localparam logic [31:0] FACT_HR  = 32'd3600000000;

	typedef struct packed {
		logic          valid;
		status_t       status;
		logic [63:0]   value;
		logic [31:0]   factor;
	} fin_t;

endpackage
`default_nettype wire

// ===== rtl/dssp_char_if.sv =====
`default_nettype none
interface dssp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/dssp_res_if.sv =====
`default_nettype none
interface dssp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] time_us;

	modport source (output valid, output status, output time_us, input ready);
	modport sink (input valid, input status, input time_us, output ready);
endinterface
`default_nettype wire

// ===== rtl/dssp_parse.sv =====
`default_nettype none
module dssp_parse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	dssp_char_if.sink        char_bus,
	input  wire logic        down_free,
	output dssp_pkg::fin_t   fin_s1
);

	dssp_pkg::phase_t  phase_q, phase_d;
	dssp_pkg::status_t ferr_q, ferr_d;
	logic [63:0] digit_q, digit_d;
	logic [31:0] factor_q, factor_d;
	logic        minus_q, minus_d;
	logic        range_q, range_d;
	dssp_pkg::fin_t fin_d;

	logic [7:0]  c;
	logic        take, is_digit, is_blank;
	logic [67:0] acc;
	logic        add;
	logic        fail;
	dssp_pkg::status_t fail_code;
	dssp_pkg::status_t fin_err;

	assign char_bus.ready = !fin_s1.valid || down_free;
	assign take = char_bus.valid && char_bus.ready;
	assign c = char_bus.char_code;

	always_comb begin
		is_digit = (c >= dssp_pkg::CH_ZERO) && (c <= dssp_pkg::CH_NINE);
		is_blank = c inside {8'h20, [8'h09:8'h0D]};
		acc = ({4'd0, digit_q} << 3) + ({4'd0, digit_q} << 1)
			+ {64'd0, c[3:0]};
	end

	always_comb begin
		phase_d = phase_q;
		ferr_d = ferr_q;
		digit_d = digit_q;
		factor_d = factor_q;
		minus_d = minus_q;
		range_d = range_q;
		add = 1'b0;
		fail = 1'b0;
		fail_code = dssp_pkg::ST_OK;
		fin_err = ferr_q;
		fin_d = fin_s1;
		if (fin_s1.valid && down_free) begin
			fin_d.valid = 1'b0;
		end
		if (take) begin
			if (c == dssp_pkg::CH_NUL) begin
				if (ferr_q == dssp_pkg::ST_OK) begin
					if (phase_q == dssp_pkg::PH_LEAD || phase_q == dssp_pkg::PH_SIGN) begin
						fin_err = dssp_pkg::ST_NODIG;
					end else if (phase_q == dssp_pkg::PH_U) begin
						fin_err = dssp_pkg::ST_GARBAGE;
					end
				end
				fin_d.valid = 1'b1;
				fin_d.value = digit_q;
				fin_d.factor = factor_q;
				if (minus_q) begin
					fin_d.status = dssp_pkg::ST_MINUS;
				end else if (range_q) begin
					fin_d.status = dssp_pkg::ST_RANGE;
				end else begin
					fin_d.status = fin_err;
				end
				phase_d = dssp_pkg::PH_LEAD;
				ferr_d = dssp_pkg::ST_OK;
				digit_d = '0;
				factor_d = dssp_pkg::FACT_US;
				minus_d = 1'b0;
				range_d = 1'b0;
			end else if (c == dssp_pkg::CH_MINUS) begin
				minus_d = 1'b1;
			end else begin
				case (phase_q)
					dssp_pkg::PH_LEAD: begin
						if (!is_blank) begin
							if (c == dssp_pkg::CH_PLUS) begin
								phase_d = dssp_pkg::PH_SIGN;
							end else if (is_digit) begin
								add = 1'b1;
								phase_d = dssp_pkg::PH_DIGITS;
							end else begin
								fail = 1'b1;
								fail_code = dssp_pkg::ST_NODIG;
							end
						end
					end
					dssp_pkg::PH_SIGN: begin
						if (is_digit) begin
							add = 1'b1;
							phase_d = dssp_pkg::PH_DIGITS;
						end else begin
							fail = 1'b1;
							fail_code = dssp_pkg::ST_NODIG;
						end
					end
					dssp_pkg::PH_DIGITS: begin
						if (is_digit) begin
							add = 1'b1;
						end else if (c == dssp_pkg::CH_U) begin
							phase_d = dssp_pkg::PH_U;
						end else if (c == dssp_pkg::CH_M) begin
							factor_d = dssp_pkg::FACT_MIN;
							phase_d = dssp_pkg::PH_M;
						end else if (c == dssp_pkg::CH_S) begin
							factor_d = dssp_pkg::FACT_SEC;
							phase_d = dssp_pkg::PH_END;
						end else if (c == dssp_pkg::CH_H) begin
							factor_d = dssp_pkg::FACT_HR;
							phase_d = dssp_pkg::PH_END;
						end else begin
							fail = 1'b1;
							fail_code = dssp_pkg::ST_SUFFIX;
						end
					end
					dssp_pkg::PH_U: begin
						if (c == dssp_pkg::CH_S) begin
							phase_d = dssp_pkg::PH_END;
						end else begin
							fail = 1'b1;
							fail_code = dssp_pkg::ST_GARBAGE;
						end
					end
					dssp_pkg::PH_M: begin
						if (c == dssp_pkg::CH_S) begin
							factor_d = dssp_pkg::FACT_MS;
							phase_d = dssp_pkg::PH_END;
						end else begin
							fail = 1'b1;
							fail_code = dssp_pkg::ST_GARBAGE;
						end
					end
					dssp_pkg::PH_END: begin
						fail = 1'b1;
						fail_code = dssp_pkg::ST_GARBAGE;
					end
					default: begin
						phase_d = dssp_pkg::PH_DONE;
					end
				endcase
				if (add) begin
					if (range_q || (acc[67:64] != 4'd0)) begin
						range_d = 1'b1;
						digit_d = '1;
					end else begin
						digit_d = acc[63:0];
					end
				end
				if (fail) begin
					phase_d = dssp_pkg::PH_DONE;
					if (ferr_q == dssp_pkg::ST_OK) begin
						ferr_d = fail_code;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dssp_pkg::PH_LEAD;
			ferr_q <= dssp_pkg::ST_OK;
			digit_q <= '0;
			factor_q <= dssp_pkg::FACT_US;
			minus_q <= 1'b0;
			range_q <= 1'b0;
			fin_s1 <= '0;
		end else begin
			phase_q <= phase_d;
			ferr_q <= ferr_d;
			digit_q <= digit_d;
			factor_q <= factor_d;
			minus_q <= minus_d;
			range_q <= range_d;
			fin_s1 <= fin_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dssp_scale.sv =====
`default_nettype none
module dssp_scale (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dssp_pkg::fin_t fin_s1,
	output logic             up_free,
	dssp_res_if.source       result_bus
);

	logic              valid_s2;
	dssp_pkg::status_t status_s2;
	logic [63:0]       lo_s2, hi_s2;
	logic              valid_q;
	logic [2:0]        status_q;
	logic [63:0]       time_q;
	logic              out_free;
	logic [95:0]       full;
	logic              ovfl;

	assign out_free = !valid_q || result_bus.ready;
	assign up_free = !valid_s2 || out_free;

	assign result_bus.valid = valid_q;
	assign result_bus.status = status_q;
	assign result_bus.time_us = time_q;

	always_comb begin
		full = {hi_s2, 32'd0} + {32'd0, lo_s2};
		ovfl = full[95:64] != 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (up_free) begin
				valid_s2 <= fin_s1.valid;
			end
			if (out_free) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_free && fin_s1.valid) begin
			status_s2 <= fin_s1.status;
			lo_s2 <= {32'd0, fin_s1.value[31:0]} * {32'd0, fin_s1.factor};
			hi_s2 <= {32'd0, fin_s1.value[63:32]} * {32'd0, fin_s1.factor};
		end
		if (out_free && valid_s2) begin
			if (status_s2 != dssp_pkg::ST_OK) begin
				status_q <= status_s2;
				time_q <= '0;
			end else if (ovfl) begin
				status_q <= dssp_pkg::ST_OVFL;
				time_q <= '0;
			end else begin
				status_q <= dssp_pkg::ST_OK;
				time_q <= full[63:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/duration_string_suffix_parser_unit.sv =====
`default_nettype none
// Streaming duration parser: one string byte per beat on char_bus, one result beat on
// result_bus per zero terminator, carrying a status and the duration in microseconds.
// Bytes stream back to back while char_bus.ready is high; a result reaches result_bus through
// the finish register, a registered pair of 64-bit partial products (each 32-bit half of
// the value times the unit factor), and the output register.
// Bytes keep flowing while results wait in the product and output registers; once the finish
// register also holds a result that cannot advance, every byte waits for the result beat.
module duration_string_suffix_parser_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	dssp_char_if.sink  char_bus,
	dssp_res_if.source result_bus
);

	dssp_pkg::fin_t fin_s1;
	logic           down_free;

	dssp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_bus (char_bus),
		.down_free(down_free),
		.fin_s1   (fin_s1)
	);

	dssp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_s1    (fin_s1),
		.up_free   (down_free),
		.result_bus(result_bus)
	);

endmodule
`default_nettype wire
